/* rtl/contiguous_region_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef CONTIGUOUS_REGION_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_REGION_ALLOCATOR_DEFINES_SVH

// Condition implies property in the same cycle.
`define CRA_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition implies property in the next cycle.
`define CRA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/cra_pkg.sv */
// Types and constants of the contiguous region allocator.
package cra_pkg;

    localparam int ADDR_BITS = 24;
    localparam int SIZE_W    = 25;
    localparam int OWNER_W   = 8;
    localparam int STATUS_W  = 3;

    localparam logic [SIZE_W-1:0] TOTAL_SIZE_RESET = 25'd1048576;
    localparam logic [SIZE_W-1:0] MEM_LIMIT        = 25'd16777216;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_COMPACT = 2'd2;
    localparam logic [1:0] CMD_REPORT  = 2'd3;

    localparam logic [1:0] POL_FIRST   = 2'd0;
    localparam logic [1:0] POL_BEST    = 2'd1;
    localparam logic [1:0] POL_WORST   = 2'd2;
    localparam logic [1:0] POL_INVALID = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NO_FIT     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_POLICY = 3'd3;
    localparam logic [STATUS_W-1:0] STS_TABLE_FULL = 3'd4;
    localparam logic [STATUS_W-1:0] STS_BAD_SIZE   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_DONE,
        ST_REL_SCAN,
        ST_REL_NEXT,
        ST_REL_PREV,
        ST_CMP_SUM,
        ST_CMP_PACK,
        ST_CMP_HOLE,
        ST_REPORT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
        logic [OWNER_W-1:0]   owner;
        logic                 used;
    } result_t;

    localparam result_t RESULT_ZERO = '0;

endpackage

/* rtl/contiguous_region_allocator.sv */
// Contiguous region allocator: segment table, command sequencer and result register.
//
// Commands arrive as beats on the s_t* channel (allocate, release, compact, report);
// results leave as beats on the m_t* channel, m_tlast set on the final beat of a
// command. The single register total_size is written on the cfg_* channel, and each
// write reinitializes the table to one hole covering the whole memory.
// A command is taken only while the sequencer is idle. The sequencer walks the table
// one entry per cycle, and report sends one beat per cycle for each table entry
// while the receiver keeps up. The next command is taken once the last beat of the
// current one is in the output register. A stalled receiver holds the output
// register; the sequencer waits and takes no new command until that beat leaves.
// Reset gives total_size 1048576 and a table with the single hole [0, 1048576).
module contiguous_region_allocator #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], req_size[26:2], owner_id[34:27], fit_policy[36:35], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], seg_start[26:3], seg_size[51:27], seg_owner[59:52],
    // seg_used[60], zero fill
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] cfg_data
);
    import cra_pkg::*;

`include "contiguous_region_allocator_defines.svh"

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SEGMENTS);

    state_t state_reg, state_next;

    logic [ADDR_BITS-1:0] entry_start_reg [MAX_SEGMENTS];
    logic [ADDR_BITS-1:0] entry_start_next[MAX_SEGMENTS];
    logic [SIZE_W-1:0]    entry_size_reg  [MAX_SEGMENTS];
    logic [SIZE_W-1:0]    entry_size_next [MAX_SEGMENTS];
    logic [OWNER_W-1:0]   entry_owner_reg [MAX_SEGMENTS];
    logic [OWNER_W-1:0]   entry_owner_next[MAX_SEGMENTS];
    logic                 entry_used_reg  [MAX_SEGMENTS];
    logic                 entry_used_next [MAX_SEGMENTS];
    logic [CW-1:0]        count_reg, count_next;

    logic [SIZE_W-1:0]  total_reg, total_next;
    logic [1:0]         pol_reg, pol_next;
    logic [SIZE_W-1:0]  req_reg, req_next;
    logic [OWNER_W-1:0] id_reg, id_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [IW-1:0]      pick_reg, pick_next;
    logic [SIZE_W-1:0]  psize_reg, psize_next;
    logic               found_reg, found_next;
    logic [SIZE_W-1:0]  acc_reg, acc_next;
    logic [SIZE_W-1:0]  addr_reg, addr_next;
    result_t            res_reg, res_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;

    logic [1:0]         in_cmd;
    logic [SIZE_W-1:0]  in_req;
    logic [OWNER_W-1:0] in_id;
    logic [1:0]         in_pol;
    logic               in_take, bad_pol, bad_size;
    logic               cur_valid, alloc_cand, rel_hit, alloc_stop, out_free;
    logic [IW-1:0]      cur_i, pick_p1, pick_m1;
    logic               nxt_free, prv_free;
    logic [SIZE_W-1:0]  cfg_val;

    assign in_cmd = s_tdata[1:0];
    assign in_req = s_tdata[26:2];
    assign in_id  = s_tdata[34:27];
    assign in_pol = s_tdata[36:35];

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign bad_pol   = (in_pol == POL_INVALID);
    assign bad_size  = (in_req == '0) || (in_req > total_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cur_i      = idx_reg[IW-1:0];
    assign cur_valid  = (idx_reg < count_reg);
    assign alloc_cand = cur_valid && !entry_used_reg[cur_i] && (entry_size_reg[cur_i] >= req_reg);
    assign rel_hit    = cur_valid && entry_used_reg[cur_i] && (entry_owner_reg[cur_i] == id_reg);
    assign alloc_stop = !cur_valid || (alloc_cand && (pol_reg == POL_FIRST));

    assign pick_p1  = pick_reg + 1'b1;
    assign pick_m1  = pick_reg - 1'b1;
    assign nxt_free = ((CW'(pick_reg) + 1'b1) < count_reg) && !entry_used_reg[pick_p1];
    assign prv_free = (pick_reg != '0) && !entry_used_reg[pick_m1];

    always_comb
    begin
        if (cfg_data == '0)
            cfg_val = 25'd1;
        else if (cfg_data > MEM_LIMIT)
            cfg_val = MEM_LIMIT;
        else
            cfg_val = cfg_data;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (in_cmd)
                        CMD_ALLOC:   state_next = (bad_pol || bad_size) ? ST_EMIT : ST_ALLOC_SCAN;
                        CMD_RELEASE: state_next = ST_REL_SCAN;
                        CMD_COMPACT: state_next = ST_CMP_SUM;
                        default:     state_next = ST_REPORT;
                    endcase
                end
            end
            ST_ALLOC_SCAN: if (alloc_stop) state_next = ST_ALLOC_DONE;
            ST_ALLOC_DONE: state_next = ST_EMIT;
            ST_REL_SCAN:
            begin
                if (!cur_valid)
                    state_next = ST_EMIT;
                else if (rel_hit)
                    state_next = ST_REL_NEXT;
            end
            ST_REL_NEXT:   state_next = ST_REL_PREV;
            ST_REL_PREV:   state_next = ST_EMIT;
            ST_CMP_SUM:    if (!cur_valid) state_next = ST_CMP_PACK;
            ST_CMP_PACK:   if (!cur_valid) state_next = ST_CMP_HOLE;
            ST_CMP_HOLE:   state_next = ST_EMIT;
            ST_REPORT:
            begin
                if (!cur_valid)
                    state_next = ST_IDLE;
                else if (out_free && ((idx_reg + 1'b1) == count_reg))
                    state_next = ST_IDLE;
            end
            ST_EMIT:       if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Table and working registers.
    always_comb
    begin
        for (int j = 0; j < MAX_SEGMENTS; j++)
        begin
            entry_start_next[j] = entry_start_reg[j];
            entry_size_next[j]  = entry_size_reg[j];
            entry_owner_next[j] = entry_owner_reg[j];
            entry_used_next[j]  = entry_used_reg[j];
        end
        count_next = count_reg;
        total_next = total_reg;
        pol_next   = pol_reg;
        req_next   = req_reg;
        id_next    = id_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        pick_next  = pick_reg;
        psize_next = psize_reg;
        found_next = found_reg;
        acc_next   = acc_reg;
        addr_next  = addr_reg;
        res_next   = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    total_next = cfg_val;
                    for (int j = 0; j < MAX_SEGMENTS; j++)
                    begin
                        entry_start_next[j] = '0;
                        entry_size_next[j]  = '0;
                        entry_owner_next[j] = '0;
                        entry_used_next[j]  = 1'b0;
                    end
                    entry_size_next[0] = cfg_val;
                    count_next = CW'(1);
                end
                else if (in_take)
                begin
                    pol_next   = in_pol;
                    req_next   = in_req;
                    id_next    = in_id;
                    idx_next   = '0;
                    k_next     = '0;
                    found_next = 1'b0;
                    acc_next   = '0;
                    res_next   = RESULT_ZERO;
                    if (in_cmd == CMD_ALLOC)
                    begin
                        if (bad_pol)
                            res_next.status = STS_BAD_POLICY;
                        else if (bad_size)
                            res_next.status = STS_BAD_SIZE;
                    end
                end
            end
            ST_ALLOC_SCAN:
            begin
                if (cur_valid)
                begin
                    if (alloc_cand)
                    begin
                        if (!found_reg
                            || ((pol_reg == POL_BEST) && (entry_size_reg[cur_i] < psize_reg))
                            || ((pol_reg == POL_WORST) && (entry_size_reg[cur_i] > psize_reg)))
                        begin
                            found_next = 1'b1;
                            pick_next  = cur_i;
                            psize_next = entry_size_reg[cur_i];
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ALLOC_DONE:
            begin
                res_next = RESULT_ZERO;
                if (!found_reg)
                    res_next.status = STS_NO_FIT;
                else if (psize_reg == req_reg)
                begin
                    entry_used_next[pick_reg]  = 1'b1;
                    entry_owner_next[pick_reg] = id_reg;
                    res_next = '{STS_OK, entry_start_reg[pick_reg], req_reg, id_reg, 1'b1};
                end
                else if (count_reg >= MAX_COUNT)
                    res_next.status = STS_TABLE_FULL;
                else
                begin
                    // Split: the request comes off the high end of the hole.
                    for (int j = 1; j < MAX_SEGMENTS; j++)
                    begin
                        if (CW'(j) > (CW'(pick_reg) + 1'b1))
                        begin
                            entry_start_next[j] = entry_start_reg[j-1];
                            entry_size_next[j]  = entry_size_reg[j-1];
                            entry_owner_next[j] = entry_owner_reg[j-1];
                            entry_used_next[j]  = entry_used_reg[j-1];
                        end
                    end
                    entry_size_next[pick_reg]  = psize_reg - req_reg;
                    entry_start_next[pick_p1]  = ADDR_BITS'(SIZE_W'(entry_start_reg[pick_reg])
                                                 + psize_reg - req_reg);
                    entry_size_next[pick_p1]   = req_reg;
                    entry_owner_next[pick_p1]  = id_reg;
                    entry_used_next[pick_p1]   = 1'b1;
                    count_next = count_reg + 1'b1;
                    res_next = '{STS_OK,
                                 ADDR_BITS'(SIZE_W'(entry_start_reg[pick_reg])
                                 + psize_reg - req_reg),
                                 req_reg, id_reg, 1'b1};
                end
            end
            ST_REL_SCAN:
            begin
                if (!cur_valid)
                    res_next.status = STS_NOT_FOUND;
                else if (rel_hit)
                begin
                    pick_next = cur_i;
                    res_next  = '{STS_OK, entry_start_reg[cur_i], entry_size_reg[cur_i],
                                  id_reg, 1'b0};
                    entry_used_next[cur_i]  = 1'b0;
                    entry_owner_next[cur_i] = '0;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_REL_NEXT:
            begin
                if (nxt_free)
                begin
                    entry_size_next[pick_reg] = entry_size_reg[pick_reg] + entry_size_reg[pick_p1];
                    for (int j = 0; j < MAX_SEGMENTS; j++)
                    begin
                        if (CW'(j) > CW'(pick_reg))
                        begin
                            if (j + 1 < MAX_SEGMENTS)
                            begin
                                entry_start_next[j] = entry_start_reg[(j+1)%MAX_SEGMENTS];
                                entry_size_next[j]  = entry_size_reg[(j+1)%MAX_SEGMENTS];
                                entry_owner_next[j] = entry_owner_reg[(j+1)%MAX_SEGMENTS];
                                entry_used_next[j]  = entry_used_reg[(j+1)%MAX_SEGMENTS];
                            end
                            else
                            begin
                                entry_start_next[j] = '0;
                                entry_size_next[j]  = '0;
                                entry_owner_next[j] = '0;
                                entry_used_next[j]  = 1'b0;
                            end
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            ST_REL_PREV:
            begin
                if (prv_free)
                begin
                    entry_size_next[pick_m1] = entry_size_reg[pick_m1] + entry_size_reg[pick_reg];
                    for (int j = 0; j < MAX_SEGMENTS; j++)
                    begin
                        if (CW'(j) >= CW'(pick_reg))
                        begin
                            if (j + 1 < MAX_SEGMENTS)
                            begin
                                entry_start_next[j] = entry_start_reg[(j+1)%MAX_SEGMENTS];
                                entry_size_next[j]  = entry_size_reg[(j+1)%MAX_SEGMENTS];
                                entry_owner_next[j] = entry_owner_reg[(j+1)%MAX_SEGMENTS];
                                entry_used_next[j]  = entry_used_reg[(j+1)%MAX_SEGMENTS];
                            end
                            else
                            begin
                                entry_start_next[j] = '0;
                                entry_size_next[j]  = '0;
                                entry_owner_next[j] = '0;
                                entry_used_next[j]  = 1'b0;
                            end
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            ST_CMP_SUM:
            begin
                if (cur_valid)
                begin
                    if (!entry_used_reg[cur_i])
                        acc_next = acc_reg + entry_size_reg[cur_i];
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    idx_next  = '0;
                    k_next    = '0;
                    addr_next = acc_reg;
                end
            end
            ST_CMP_PACK:
            begin
                // The write slot never runs ahead of the read slot, so packing in place is safe.
                if (cur_valid)
                begin
                    if (entry_used_reg[cur_i])
                    begin
                        entry_start_next[k_reg[IW-1:0]] = addr_reg[ADDR_BITS-1:0];
                        entry_size_next[k_reg[IW-1:0]]  = entry_size_reg[cur_i];
                        entry_owner_next[k_reg[IW-1:0]] = entry_owner_reg[cur_i];
                        entry_used_next[k_reg[IW-1:0]]  = 1'b1;
                        addr_next = addr_reg + entry_size_reg[cur_i];
                        k_next    = k_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CMP_HOLE:
            begin
                // Owned segments sit in slots below k; a nonzero hole shifts them up by one.
                if (acc_reg != '0)
                begin
                    entry_start_next[0] = '0;
                    entry_size_next[0]  = acc_reg;
                    entry_owner_next[0] = '0;
                    entry_used_next[0]  = 1'b0;
                    for (int j = 1; j < MAX_SEGMENTS; j++)
                    begin
                        if (CW'(j) <= k_reg)
                        begin
                            entry_start_next[j] = entry_start_reg[j-1];
                            entry_size_next[j]  = entry_size_reg[j-1];
                            entry_owner_next[j] = entry_owner_reg[j-1];
                            entry_used_next[j]  = entry_used_reg[j-1];
                        end
                        else
                        begin
                            entry_start_next[j] = '0;
                            entry_size_next[j]  = '0;
                            entry_owner_next[j] = '0;
                            entry_used_next[j]  = 1'b0;
                        end
                    end
                end
                else
                begin
                    for (int j = 0; j < MAX_SEGMENTS; j++)
                    begin
                        if (CW'(j) >= k_reg)
                        begin
                            entry_start_next[j] = '0;
                            entry_size_next[j]  = '0;
                            entry_owner_next[j] = '0;
                            entry_used_next[j]  = 1'b0;
                        end
                    end
                end
                count_next = (acc_reg != '0) ? (k_reg + 1'b1) : k_reg;
                res_next   = '{STS_OK, '0, acc_reg, '0, 1'b0};
            end
            ST_REPORT:
            begin
                if (cur_valid && out_free)
                    idx_next = idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register and result beats.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_reg.used, res_reg.owner, res_reg.size,
                                     res_reg.start, res_reg.status};
                    m_tlast_next  = 1'b1;
                end
            end
            ST_REPORT:
            begin
                if (cur_valid && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, entry_used_reg[cur_i],
                                     entry_used_reg[cur_i] ? entry_owner_reg[cur_i] : 8'd0,
                                     entry_size_reg[cur_i], entry_start_reg[cur_i], STS_OK};
                    m_tlast_next  = ((idx_reg + 1'b1) == count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= CW'(1);
            total_reg    <= TOTAL_SIZE_RESET;
            m_tvalid_reg <= 1'b0;
            for (int j = 0; j < MAX_SEGMENTS; j++)
            begin
                entry_start_reg[j] <= '0;
                entry_size_reg[j]  <= (j == 0) ? TOTAL_SIZE_RESET : '0;
                entry_owner_reg[j] <= '0;
                entry_used_reg[j]  <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int j = 0; j < MAX_SEGMENTS; j++)
            begin
                entry_start_reg[j] <= entry_start_next[j];
                entry_size_reg[j]  <= entry_size_next[j];
                entry_owner_reg[j] <= entry_owner_next[j];
                entry_used_reg[j]  <= entry_used_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pol_reg     <= pol_next;
        req_reg     <= req_next;
        id_reg      <= id_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        pick_reg    <= pick_next;
        psize_reg   <= psize_next;
        found_reg   <= found_next;
        acc_reg     <= acc_next;
        addr_reg    <= addr_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    `CRA_ASSERT_NEXT(a_busy_after_cmd, s_tvalid && s_tready, !s_tready, "ready after command beat")
    `CRA_ASSERT_NEXT(a_cfg_reinit, cfg_valid && cfg_ready, count_reg == CW'(1), "table not reset by cfg")
    `CRA_ASSERT_NOW(a_idle_count, s_tready, (count_reg != '0) && (count_reg <= MAX_COUNT), "bad count")

endmodule
